// ----- sv/calendar_date_day_adder_assert.svh -----
// assertion macros for the calendar date day adder
`ifndef CALENDAR_DATE_DAY_ADDER_ASSERT_SVH
`define CALENDAR_DATE_DAY_ADDER_ASSERT_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define CDDA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define CDDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CDDA_ASSERT_ALWAYS(label, expr, msg)
`define CDDA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- sv/cdda_pkg.sv -----
package cdda_pkg;

  typedef logic [13:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [2:0]  weekday_t;
  typedef logic [1:0]  status_t;
  typedef logic [6:0]  yy_t;
  typedef logic [7:0]  century_t;

  // flags from the shared compare/subtract unit
  typedef struct packed {
    logic ge;
    logic gt;
  } sub_flags_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_INVALID  = 2'd1;
  localparam status_t STAT_OVERFLOW = 2'd2;

  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_DEC = 4'd12;

  // leap test from year mod 100 and year / 100
  function automatic logic is_leap(input yy_t yy, input century_t c);
    is_leap = (yy[1:0] == 2'd0) && ((yy != 7'd0) || (c[1:0] == 2'd0));
  endfunction

  // days in a month, any code outside 1..12 counts as 31
  function automatic day_t month_len(input month_t m, input logic leap);
    case (m)
      4'd2:    month_len = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

  // key value of each month
  function automatic logic [2:0] month_key(input month_t m);
    case (m)
      4'd1:    month_key = 3'd1;
      4'd2:    month_key = 3'd4;
      4'd3:    month_key = 3'd4;
      4'd4:    month_key = 3'd0;
      4'd5:    month_key = 3'd2;
      4'd6:    month_key = 3'd5;
      4'd7:    month_key = 3'd0;
      4'd8:    month_key = 3'd3;
      4'd9:    month_key = 3'd6;
      4'd10:   month_key = 3'd1;
      4'd11:   month_key = 3'd4;
      4'd12:   month_key = 3'd6;
      default: month_key = 3'd0;
    endcase
  endfunction

  // century code by table index
  function automatic logic [2:0] century_code(input logic [1:0] idx);
    case (idx)
      2'd0:    century_code = 3'd4;
      2'd1:    century_code = 3'd2;
      2'd2:    century_code = 3'd0;
      default: century_code = 3'd6;
    endcase
  endfunction

endpackage

// ----- sv/cdda_sub_unit.sv -----
module cdda_sub_unit #(
  parameter int W = 14
) (
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  output logic [W-1:0]         diff,
  output cdda_pkg::sub_flags_t flags
);
  import cdda_pkg::*;

  logic borrow;

  // one subtractor serves year mod 100, month stepping and mod 7
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign flags.ge = !borrow;
  assign flags.gt = !borrow && (diff != '0);

endmodule

// ----- sv/cdda_wday_sum.sv -----
module cdda_wday_sum (
  input  cdda_pkg::yy_t      yy,
  input  cdda_pkg::century_t c,
  input  cdda_pkg::month_t   month,
  input  cdda_pkg::day_t     day,
  output logic [7:0]         sum
);
  import cdda_pkg::*;

  logic       jan_feb_leap;
  logic [1:0] cc_idx;

  // leap years take one off in january and february
  assign jan_feb_leap = ((month == MONTH_JAN) || (month == MONTH_FEB)) && is_leap(yy, c);
  assign cc_idx = c[1:0] - 2'd1;

  // key value sum, reduced mod 7 by the sequencer
  assign sum = 8'(yy[6:2]) + 8'(day) + 8'(yy) + 8'd7
             + 8'(month_key(month)) + 8'(century_code(cc_idx))
             - 8'(jan_feb_leap);

endmodule

// ----- sv/calendar_date_day_adder.sv -----
// a load passes through S_DIV, S_REM, S_CHECK, S_WSUM and S_MOD7 to S_DONE
// an add steps through S_STEP one month end at a time, then S_WSUM, S_MOD7 and S_DONE;
// it stops stepping when the year would pass the last year
// throughput: one word at a time, in_ready is high only while the sequencer is idle
// a waiting result sits in the output register while the next word is accepted
// reset: synchronous active-high rst sets the date to january 1, 2001 and clears valids
`include "calendar_date_day_adder_assert.svh"

module calendar_date_day_adder #(
  parameter int MAX_YEAR   = 9999,
  parameter int COUNT_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  cdda_pkg::year_t       load_year,
  input  cdda_pkg::month_t      load_month,
  input  cdda_pkg::day_t        load_day,
  input  logic [COUNT_BITS-1:0] day_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cdda_pkg::year_t       year_out,
  output cdda_pkg::month_t      month_out,
  output cdda_pkg::day_t        day_out,
  output cdda_pkg::weekday_t    weekday,
  output cdda_pkg::status_t     status
);
  import cdda_pkg::*;

  localparam int W = (COUNT_BITS + 1 > 14) ? COUNT_BITS + 1 : 14;
  localparam year_t       MAX_Y    = 14'(MAX_YEAR);
  localparam logic [W-1:0] DIV_BASE = W'(100);
  localparam logic [W-1:0] MOD_BASE = W'(7);
  localparam logic [26:0] DIV_RECIP = 27'd5243;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_WSUM  = 3'd4;
  localparam logic [2:0] S_MOD7  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_REM   = 3'd7;

  logic [2:0] state;

  // stored date with its split year
  year_t    year_reg;
  month_t   month_reg;
  day_t     day_reg;
  yy_t      yy_reg;
  century_t c_reg;

  // working copies
  logic [W-1:0] acc;
  year_t        wy;
  month_t       wm;
  day_t         wd;
  yy_t          wyy;
  century_t     wc;
  status_t      res_status;

  logic [W-1:0] sub_b;
  logic [W-1:0] sub_diff;
  sub_flags_t   sub_flags;
  logic [7:0]   wsum;
  logic [4:0]   fold1;
  logic [3:0]   fold2;
  logic [26:0]  div_prod;
  century_t     div_quot;
  logic         step_leap;
  logic         chk_leap;
  logic         load_ok;
  year_t        split_year;
  logic         day_fits;

  assign in_ready  = (state == S_IDLE);
  assign step_leap = is_leap(wyy, wc);
  assign chk_leap  = is_leap(acc[6:0], wc);
  assign load_ok   = (wy <= MAX_Y) && (wm >= MONTH_JAN) && (wm <= MONTH_DEC) &&
                     (wd != 5'd0) && (wd <= month_len(wm, chk_leap));

  // year / 100 by reciprocal multiplication, exact for every 14-bit year
  assign div_prod = 27'(acc[13:0]) * DIV_RECIP;
  assign div_quot = div_prod[26:19];

  // fold the weekday sum in 3-bit groups, 8 = 1 mod 7
  assign fold1 = 5'(wsum[7:6]) + 5'(wsum[5:3]) + 5'(wsum[2:0]);
  assign fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);

  // operand select for the shared subtractor
  always_comb begin
    case (state)
      S_REM:   sub_b = W'(wc) * DIV_BASE;
      S_STEP:  sub_b = W'(month_len(wm, step_leap));
      S_MOD7:  sub_b = MOD_BASE;
      default: sub_b = '0;
    endcase
  end

  cdda_sub_unit #(.W(W)) u_sub (
    .a     (acc),
    .b     (sub_b),
    .diff  (sub_diff),
    .flags (sub_flags)
  );

  cdda_wday_sum u_wsum (
    .yy    (yy_reg),
    .c     (c_reg),
    .month (month_reg),
    .day   (day_reg),
    .sum   (wsum)
  );

  // sequencer and stored date
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      year_reg  <= 14'd2001;
      month_reg <= MONTH_JAN;
      day_reg   <= 5'd1;
      yy_reg    <= 7'd1;
      c_reg     <= 8'd20;
    end else begin
      // the output register frees on a taken word unless a new one loads
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation == OP_LOAD) begin
              acc   <= W'(load_year);
              wy    <= load_year;
              wm    <= load_month;
              wd    <= load_day;
              wc    <= '0;
              state <= S_DIV;
            end else begin
              acc   <= W'(day_count) + W'(day_reg);
              wy    <= year_reg;
              wm    <= month_reg;
              wyy   <= yy_reg;
              wc    <= c_reg;
              state <= S_STEP;
            end
          end
        end
        // century of the loaded year
        S_DIV: begin
          wc    <= div_quot;
          state <= S_REM;
        end
        // year mod 100 on the shared subtractor
        S_REM: begin
          acc   <= sub_diff;
          state <= S_CHECK;
        end
        // validate the loaded date and commit it when valid
        S_CHECK: begin
          if (load_ok) begin
            year_reg   <= wy;
            month_reg  <= wm;
            day_reg    <= wd;
            yy_reg     <= acc[6:0];
            c_reg      <= wc;
            res_status <= STAT_OK;
          end else begin
            res_status <= STAT_INVALID;
          end
          state <= S_WSUM;
        end
        // one month a cycle until the day fits or the year would pass the last year
        S_STEP: begin
          if (sub_flags.gt) begin
            acc <= sub_diff;
            if (wm >= MONTH_DEC) begin
              wm <= MONTH_JAN;
              if (wy >= MAX_Y) begin
                res_status <= STAT_OVERFLOW;
                state      <= S_WSUM;
              end else begin
                wy <= wy + 14'd1;
                if (wyy == 7'd99) begin
                  wyy <= '0;
                  wc  <= wc + 8'd1;
                end else begin
                  wyy <= wyy + 7'd1;
                end
              end
            end else begin
              wm <= wm + 4'd1;
            end
          end else begin
            year_reg   <= wy;
            month_reg  <= wm;
            day_reg    <= acc[4:0];
            yy_reg     <= wyy;
            c_reg      <= wc;
            res_status <= STAT_OK;
            state      <= S_WSUM;
          end
        end
        S_WSUM: begin
          acc   <= W'(fold2);
          state <= S_MOD7;
        end
        // folded sum is at most 8, one subtract of 7 finishes mod 7
        S_MOD7: begin
          if (sub_flags.ge) begin
            acc <= sub_diff;
          end
          state <= S_DONE;
        end
        // hand the word to the output register once it is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            year_out  <= year_reg;
            month_out <= month_reg;
            day_out   <= day_reg;
            weekday   <= (acc[2:0] == 3'd0) ? 3'd6 : acc[2:0] - 3'd1;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // stored date views for the checks
  assign split_year = 14'(c_reg) * 14'd100 + 14'(yy_reg);
  assign day_fits   = (day_reg != 5'd0) &&
                      (day_reg <= month_len(month_reg, is_leap(yy_reg, c_reg)));

  // checks on the sequencer and the stored date
  `CDDA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `CDDA_ASSERT_ALWAYS(a_split_year, split_year == year_reg, "split year mismatch")
  `CDDA_ASSERT_ALWAYS(a_day_fits, day_fits, "stored day out of month")
  `CDDA_ASSERT_ALWAYS(a_weekday_range, !out_valid || (weekday <= 3'd6), "weekday out of range")

endmodule

// ----- verif/calendar_result_check.sv -----
`timescale 1ns / 100ps

module calendar_result_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               operation,
  input  cdda_pkg::year_t    load_year,
  input  cdda_pkg::month_t   load_month,
  input  cdda_pkg::day_t     load_day,
  input  logic [11:0]        day_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cdda_pkg::year_t    year_out,
  input  cdda_pkg::month_t   month_out,
  input  cdda_pkg::day_t     day_out,
  input  cdda_pkg::weekday_t weekday,
  input  cdda_pkg::status_t  status,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count,
  output int                 invalid_count,
  output int                 overflow_count
);
  import cdda_pkg::*;

  localparam int LAST_YEAR = 9999;

  typedef struct {
    year_t    year;
    month_t   month;
    day_t     day;
    weekday_t wday;
    status_t  code;
  } date_word_t;

  int key_of_month [12] = '{1, 4, 4, 0, 2, 5, 0, 3, 6, 1, 4, 6};
  int century_offset [4] = '{4, 2, 0, 6};

  // date currently held by the block
  int held_year;
  int held_month;
  int held_day;

  date_word_t due_dates[$];

  function automatic bit leap_year(input int y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int month_days(input int y, input int m);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // key-value weekday, 0 = sunday
  function automatic weekday_t weekday_from_date(input int y, input int m, input int d);
    int yy;
    int s;
    yy = y % 100;
    s = yy / 4 + d + yy + 7 + key_of_month[m - 1] + century_offset[((y / 100) % 4 + 3) % 4];
    if (m <= 2 && leap_year(y)) s = s - 1;
    return weekday_t'(((s % 7) + 6) % 7);
  endfunction

  // date and status after one word, from the held date
  function automatic date_word_t next_date(input logic op, input year_t ly,
      input month_t lm, input day_t ld, input logic [11:0] cnt);
    date_word_t r;
    int y;
    int m;
    int total;
    bit over;
    y = held_year;
    m = held_month;
    total = held_day;
    r.code = STAT_OK;
    if (op == OP_LOAD) begin
      if (ly > LAST_YEAR || lm < 1 || lm > 12 || ld == 0 || ld > month_days(ly, lm)) begin
        r.code = STAT_INVALID;
      end else begin
        y = ly;
        m = lm;
        total = ld;
      end
    end else begin
      // walk month by month, december rolls into the next year
      total = held_day + cnt;
      over = 1'b0;
      while (!over && total > month_days(y, m)) begin
        total = total - month_days(y, m);
        if (m >= 12) begin
          m = 1;
          if (y >= LAST_YEAR) over = 1'b1;
          else y = y + 1;
        end else begin
          m = m + 1;
        end
      end
      if (over) begin
        r.code = STAT_OVERFLOW;
        y = held_year;
        m = held_month;
        total = held_day;
      end
    end
    r.year = year_t'(y);
    r.month = month_t'(m);
    r.day = day_t'(total);
    r.wday = weekday_from_date(y, m, total);
    return r;
  endfunction

  // result side first: a word accepted on this edge cannot answer itself
  always @(posedge clk) begin
    date_word_t want;
    date_word_t got;
    if (rst) begin
      held_year = 2001;
      held_month = 1;
      held_day = 1;
      due_dates.delete();
      fail_count = 0;
      result_count = 0;
      invalid_count = 0;
      overflow_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count = result_count + 1;
        if (due_dates.size() == 0) begin
          $error("result word with no expected date waiting");
          fail_count = fail_count + 1;
        end else begin
          want = due_dates.pop_front();
          if (want.code == STAT_INVALID) invalid_count = invalid_count + 1;
          if (want.code == STAT_OVERFLOW) overflow_count = overflow_count + 1;
          if (year_out !== want.year) begin
            $error("year_out: expected %0d, got %0d", want.year, year_out);
            fail_count = fail_count + 1;
          end
          if (month_out !== want.month) begin
            $error("month_out: expected %0d, got %0d", want.month, month_out);
            fail_count = fail_count + 1;
          end
          if (day_out !== want.day) begin
            $error("day_out: expected %0d, got %0d", want.day, day_out);
            fail_count = fail_count + 1;
          end
          if (weekday !== want.wday) begin
            $error("weekday: expected %0d, got %0d", want.wday, weekday);
            fail_count = fail_count + 1;
          end
          if (status !== want.code) begin
            $error("status: expected %0d, got %0d", want.code, status);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        got = next_date(operation, load_year, load_month, load_day, day_count);
        held_year = got.year;
        held_month = got.month;
        held_day = got.day;
        due_dates.push_back(got);
      end
    end
    pending = due_dates.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import cdda_pkg::*;

  localparam int RANDOM_PER_PACE = 175;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_LOAD;
  year_t       load_year = '0;
  month_t      load_month = '0;
  day_t        load_day = '0;
  logic [11:0] day_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  year_t       year_out;
  month_t      month_out;
  day_t        day_out;
  weekday_t    weekday;
  status_t     status;

  int fail_count;
  int pending;
  int result_count;
  int invalid_count;
  int overflow_count;

  int tx_idle = 0;
  int rx_idle = 0;
  int load_words = 0;
  int add_words = 0;
  int cycle_count = 0;
  int pace;

  calendar_date_day_adder dut (.*);

  calendar_result_check result_check (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // reset starts high and is released on a falling edge
  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dates still due", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // present one word after optional idle cycles and hold it until taken
  task automatic send_word(input logic op, input year_t y, input month_t m, input day_t d,
      input logic [11:0] n);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    operation = op;
    load_year = y;
    load_month = m;
    load_day = d;
    day_count = n;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD) load_words++;
    else add_words++;
    @(negedge clk);
  endtask

  // mostly plausible dates and adds, some raw noise
  task automatic random_word();
    int r;
    int sel;
    year_t y;
    month_t m;
    day_t d;
    logic [11:0] n;
    r = $urandom_range(0, 99);
    y = year_t'($urandom);
    m = month_t'($urandom);
    d = day_t'($urandom);
    n = 12'($urandom);
    if (r < 30) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) y = year_t'($urandom_range(9990, 9999));
      else if (sel == 1) y = year_t'($urandom_range(0, 99) * 100);
      else if (sel == 2) y = year_t'($urandom_range(0, 3));
      else y = year_t'($urandom_range(0, 9999));
      m = month_t'($urandom_range(1, 12));
      if ($urandom_range(0, 3) == 0) d = day_t'($urandom_range(29, 31));
      else d = day_t'($urandom_range(1, 28));
      send_word(OP_LOAD, y, m, d, n);
    end else if (r < 38) begin
      send_word(OP_LOAD, y, m, d, n);
    end else begin
      sel = $urandom_range(0, 2);
      if (sel == 0) n = 12'($urandom_range(0, 40));
      else if (sel == 1) n = 12'($urandom_range(300, 800));
      send_word(OP_ADD, y, m, d, n);
    end
  endtask

  initial begin
    do @(negedge clk); while (rst);
    for (pace = 0; pace < 3; pace++) begin
      tx_idle = (pace == 0) ? 25 : (pace == 1) ? 59 : 0;
      rx_idle = (pace == 0) ? 59 : (pace == 1) ? 25 : 0;
      if (pace == 0) begin
        // zero count and a single day from the reset date
        send_word(OP_ADD, 0, 0, 0, 0);
        send_word(OP_ADD, 0, 0, 0, 1);
        // year zero is a leap year, then the largest count
        send_word(OP_LOAD, 0, MONTH_FEB, 29, 0);
        send_word(OP_ADD, 0, 0, 0, 12'hFFF);
        // century and ordinary leap rules
        send_word(OP_LOAD, 1900, MONTH_FEB, 29, 0);
        send_word(OP_LOAD, 2000, MONTH_FEB, 29, 0);
        send_word(OP_LOAD, 2023, MONTH_FEB, 29, 0);
        send_word(OP_LOAD, 2024, MONTH_FEB, 29, 0);
        // invalid month, day and year codes
        send_word(OP_LOAD, 2024, 0, 5, 0);
        send_word(OP_LOAD, 2024, 13, 5, 0);
        send_word(OP_LOAD, 2024, 15, 31, 0);
        send_word(OP_LOAD, 2024, 3, 0, 0);
        send_word(OP_LOAD, 2024, 4, 31, 0);
        send_word(OP_LOAD, 10000, MONTH_JAN, 1, 0);
        send_word(OP_LOAD, 14'h3FFF, MONTH_DEC, 31, 0);
        // december rolls into the next year
        send_word(OP_LOAD, 1999, MONTH_DEC, 31, 0);
        send_word(OP_ADD, 0, 0, 0, 1);
        send_word(OP_LOAD, 9998, MONTH_DEC, 31, 0);
        send_word(OP_ADD, 0, 0, 0, 1);
        // passing the last year keeps the date
        send_word(OP_LOAD, 9999, MONTH_DEC, 31, 0);
        send_word(OP_ADD, 0, 0, 0, 1);
        send_word(OP_ADD, 0, 0, 0, 0);
        send_word(OP_LOAD, 9999, MONTH_JAN, 1, 0);
        send_word(OP_ADD, 0, 0, 0, 12'hFFF);
        send_word(OP_ADD, 0, 0, 0, 364);
      end
      repeat (RANDOM_PER_PACE) random_word();
    end
    in_valid = 1'b0;

    // drain, then watch for stray results
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d load and %0d add words over three pacing phases", load_words, add_words);
    $display("checked %0d results, %0d invalid loads and %0d year overflows among them",
             result_count, invalid_count, overflow_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
